/* design/umx_pkg.sv */
`timescale 1ns / 1ps

package umx_pkg;

	localparam int SEGMENT_COUNT_DEF = 64;
	localparam int SEGMENT_WORDS_DEF = 1024;

	// Instruction word layout.
	localparam int OP_LSB  = 28;
	localparam int IMM_REG = 25;
	localparam int IMM_W   = 25;
	localparam int FA_LSB  = 6;
	localparam int FB_LSB  = 3;

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_HALT  = 2'd1;
	localparam logic [1:0] ST_FAULT = 2'd2;

	typedef enum logic [3:0] {
		OP_CMOV  = 4'd0,
		OP_LOAD  = 4'd1,
		OP_STORE = 4'd2,
		OP_ADD   = 4'd3,
		OP_MUL   = 4'd4,
		OP_DIV   = 4'd5,
		OP_NAND  = 4'd6,
		OP_HALT  = 4'd7,
		OP_MAP   = 4'd8,
		OP_UNMAP = 4'd9,
		OP_OUT   = 4'd10,
		OP_IN    = 4'd11,
		OP_LOADP = 4'd12,
		OP_IMM   = 4'd13
	} op_t;

	typedef struct packed {
		logic latch;
		logic append;
		logic fetch;
		logic rd_bc;
		logic rd_a;
		logic exec;
		logic div_start;
		logic div_write;
		logic len_rd;
		logic map_pop;
		logic map_fresh;
		logic pop_take;
		logic zero_wr;
		logic map_fin;
		logic unmap;
		logic ld_rd;
		logic ld_wr;
		logic st_wr;
		logic cp_init;
		logic cp_rd;
		logic cp_wr;
		logic lp_fin;
		logic set_fault;
		logic set_halt;
	} cmd_t;

	typedef struct packed {
		logic stopped;
		logic exec_cmd;
		logic app_full;
		logic pc_oob;
		op_t  op;
		logic rc_zero;
		logic map_bad_size;
		logic stack_empty;
		logic fresh_out;
		logic unmap_bad;
		logic acc_ok;
		logic lp_zero;
		logic div_done;
		logic k_last;
	} sts_t;

endpackage

/* design/segmented_um_instruction_executor.sv */
`timescale 1ns / 1ps

// Channel   Ports                                               Transfer
// command   start, busy, command, program_word, input_byte,     start && !busy
//           input_end
// result    done, status, output_valid, output_byte,            done (one cycle)
//           input_taken, program_counter
//
// An append passes through dispatch, the append step and the response; a
// stopped machine goes from dispatch straight to the response. Instructions
// pass through fetch, two register reads and execute; loads and stores add a
// check step, loads also a register write. Divide waits for the bit-serial
// divider; map zeroes each word in turn; load program reads, then writes, each word copied.
// Reset is asynchronous; segment memory needs no clearing pass.
// The receiver cannot stall: done is high for a single cycle.

module segmented_um_instruction_executor import umx_pkg::*; #(
	parameter int SEGMENT_COUNT = SEGMENT_COUNT_DEF,
	parameter int SEGMENT_WORDS = SEGMENT_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [31:0] program_word,
	input  logic [7:0]  input_byte,
	input  logic        input_end,
	output logic        done,
	output logic [1:0]  status,
	output logic        output_valid,
	output logic [7:0]  output_byte,
	output logic        input_taken,
	output logic [9:0]  program_counter
);

	cmd_t cmd;
	sts_t sts;

	umx_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	umx_dp #(
		.SEGMENT_COUNT (SEGMENT_COUNT),
		.SEGMENT_WORDS (SEGMENT_WORDS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.command         (command),
		.program_word    (program_word),
		.input_byte      (input_byte),
		.input_end       (input_end),
		.status          (status),
		.output_valid    (output_valid),
		.output_byte     (output_byte),
		.input_taken     (input_taken),
		.program_counter (program_counter)
	);

endmodule

/* design/umx_div.sv */
`timescale 1ns / 1ps

module umx_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic [31:0] quotient,
	output logic        done
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [33:0] diff;

	// Restoring division, one quotient bit per cycle.
	assign shifted = {rem_q, quo_q[31]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 6'd1);
			if (start) begin
				cnt_q <= 6'd32;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (diff[33]) begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end else begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

/* design/umx_dp.sv */
`timescale 1ns / 1ps

module umx_dp import umx_pkg::*; #(
	parameter int SEGMENT_COUNT = SEGMENT_COUNT_DEF,
	parameter int SEGMENT_WORDS = SEGMENT_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        command,
	input  logic [31:0] program_word,
	input  logic [7:0]  input_byte,
	input  logic        input_end,
	output logic [1:0]  status,
	output logic        output_valid,
	output logic [7:0]  output_byte,
	output logic        input_taken,
	output logic [9:0]  program_counter
);

	localparam longint unsigned MEM_DEPTH = longint'(SEGMENT_COUNT) * longint'(SEGMENT_WORDS);
	localparam int AW    = $clog2(MEM_DEPTH);
	localparam int ID_W  = $clog2(SEGMENT_COUNT);
	localparam int CNT_W = $clog2(SEGMENT_COUNT + 1);
	localparam int PC_W  = $clog2(SEGMENT_WORDS);
	localparam int LEN_W = $clog2(SEGMENT_WORDS + 1);

	logic [31:0]      regs_q [8];
	logic [PC_W-1:0]  pc_q;
	logic [LEN_W-1:0] len0_q;
	logic [1:0]       run_q;
	logic [CNT_W-1:0] depth_q;
	logic [CNT_W-1:0] fresh_q;
	logic             mapped_q [SEGMENT_COUNT];
	logic             ov_q;
	logic [7:0]       ob_q;
	logic             it_q;

	logic [31:0]      seg_mem_q [0:MEM_DEPTH-1];
	logic [31:0]      mem_rd_q;
	logic [LEN_W-1:0] len_mem_q [SEGMENT_COUNT];
	logic [LEN_W-1:0] len_rd_q;
	logic [ID_W-1:0]  stk_mem_q [SEGMENT_COUNT];
	logic [ID_W-1:0]  stk_rd_q;

	logic             cmd_q;
	logic [31:0]      word_q;
	logic [7:0]       inb_q;
	logic             inend_q;
	logic [31:0]      instr_q;
	logic [31:0]      ra_q;
	logic [31:0]      rb_q;
	logic [31:0]      rc_q;
	logic [ID_W-1:0]  id_q;
	logic [LEN_W-1:0] k_q;
	logic [LEN_W-1:0] size_q;

	op_t              op;
	logic [2:0]       fa;
	logic [2:0]       fb;
	logic [2:0]       fc;
	logic [31:0]      acc_id;
	logic [31:0]      acc_off;
	logic [ID_W-1:0]  acc_lo;
	logic             id_ok;
	logic [LEN_W-1:0] len_sel;
	logic [CNT_W-1:0] dm1;
	logic [PC_W:0]    pc_inc;
	logic [PC_W-1:0]  pc_nx;
	logic [AW-1:0]    seg_addr;
	logic [ID_W-1:0]  addr_id;
	logic [LEN_W-1:0] addr_off;
	logic             mem_we;
	logic             mem_re;
	logic [AW-1:0]    mem_wa;
	logic [AW-1:0]    mem_ra;
	logic [31:0]      mem_wd;
	logic             rf_we;
	logic [2:0]       rf_wa;
	logic [31:0]      rf_wd;
	logic [31:0]      quot;
	logic             div_done;
	logic [31:0]      pc_ext;

	assign op = op_t'(instr_q[31:OP_LSB]);
	assign fa = instr_q[FA_LSB +: 3];
	assign fb = instr_q[FB_LSB +: 3];
	assign fc = instr_q[2:0];

	// Segment accesses: store addresses by A with offset B, the others by B with offset C.
	assign acc_id  = (op == OP_STORE) ? ra_q : rb_q;
	assign acc_off = (op == OP_STORE) ? rb_q : rc_q;
	assign acc_lo  = acc_id[ID_W-1:0];
	assign id_ok   = (acc_id == '0) ||
		((acc_id < 32'(SEGMENT_COUNT)) && mapped_q[acc_lo]);
	assign len_sel = (acc_id == '0) ? len0_q : len_rd_q;

	assign dm1    = depth_q - CNT_W'(1);
	assign pc_inc = {1'b0, pc_q} + (PC_W+1)'(1);
	assign pc_nx  = (pc_inc >= (PC_W+1)'(SEGMENT_WORDS)) ? '0 : pc_inc[PC_W-1:0];

	always_comb begin
		sts              = '0;
		sts.stopped      = (run_q != ST_RUN);
		sts.exec_cmd     = cmd_q;
		sts.app_full     = (len0_q >= LEN_W'(SEGMENT_WORDS));
		sts.pc_oob       = (LEN_W'(pc_q) >= len0_q);
		sts.op           = op;
		sts.rc_zero      = (rc_q == '0);
		sts.map_bad_size = (rc_q > 32'(SEGMENT_WORDS));
		sts.stack_empty  = (depth_q == '0);
		sts.fresh_out    = (fresh_q >= CNT_W'(SEGMENT_COUNT));
		sts.unmap_bad    = (rc_q == '0) || (rc_q >= 32'(SEGMENT_COUNT)) ||
			!mapped_q[rc_q[ID_W-1:0]] || (depth_q >= CNT_W'(SEGMENT_COUNT));
		sts.acc_ok       = id_ok && (acc_off < 32'(len_sel));
		sts.lp_zero      = (rb_q == '0);
		sts.div_done     = div_done;
		sts.k_last       = (k_q == size_q);
	end

	umx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rb_q),
		.divisor  (rc_q),
		.quotient (quot),
		.done     (div_done)
	);

	// Segment memory ports.
	assign addr_id  = (cmd.ld_rd || cmd.st_wr) ? acc_lo : id_q;
	assign addr_off = (cmd.ld_rd || cmd.st_wr) ? acc_off[LEN_W-1:0] : k_q;
	assign seg_addr = AW'(addr_id) * AW'(SEGMENT_WORDS) + AW'(addr_off);

	assign mem_we = cmd.append || cmd.st_wr || cmd.zero_wr || cmd.cp_wr;
	assign mem_re = cmd.fetch || cmd.ld_rd || cmd.cp_rd;
	assign mem_ra = cmd.fetch ? AW'(pc_q) : seg_addr;

	always_comb begin
		mem_wa = seg_addr;
		mem_wd = '0;
		if (cmd.append) begin
			mem_wa = AW'(len0_q);
			mem_wd = word_q;
		end else if (cmd.cp_wr) begin
			mem_wa = AW'(k_q);
			mem_wd = mem_rd_q;
		end else if (cmd.st_wr) begin
			mem_wd = rc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			seg_mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= seg_mem_q[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.map_fin) begin
			len_mem_q[id_q] <= size_q;
		end
		if (cmd.len_rd) begin
			len_rd_q <= len_mem_q[acc_lo];
		end
		if (cmd.unmap) begin
			stk_mem_q[depth_q[ID_W-1:0]] <= rc_q[ID_W-1:0];
		end
		if (cmd.map_pop) begin
			stk_rd_q <= stk_mem_q[dm1[ID_W-1:0]];
		end
	end

	// Register file write port.
	always_comb begin
		rf_we = 1'b0;
		rf_wa = fa;
		rf_wd = rb_q;
		if (cmd.exec) begin
			case (op)
				OP_CMOV: begin
					rf_we = (rc_q != '0);
				end
				OP_ADD: begin
					rf_we = 1'b1;
					rf_wd = rb_q + rc_q;
				end
				OP_MUL: begin
					rf_we = 1'b1;
					rf_wd = rb_q * rc_q;
				end
				OP_NAND: begin
					rf_we = 1'b1;
					rf_wd = ~(rb_q & rc_q);
				end
				OP_IMM: begin
					rf_we = 1'b1;
					rf_wa = instr_q[IMM_REG +: 3];
					rf_wd = 32'(instr_q[IMM_W-1:0]);
				end
				OP_IN: begin
					rf_we = 1'b1;
					rf_wa = fc;
					rf_wd = inend_q ? '1 : 32'(inb_q);
				end
				default: begin
					rf_we = 1'b0;
				end
			endcase
		end else if (cmd.div_write) begin
			rf_we = 1'b1;
			rf_wd = quot;
		end else if (cmd.map_fin) begin
			rf_we = 1'b1;
			rf_wa = fb;
			rf_wd = 32'(id_q);
		end else if (cmd.ld_wr) begin
			rf_we = 1'b1;
			rf_wd = mem_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				regs_q[i] <= '0;
			end
			for (int i = 0; i < SEGMENT_COUNT; i++) begin
				mapped_q[i] <= 1'b0;
			end
			pc_q    <= '0;
			len0_q  <= '0;
			run_q   <= ST_RUN;
			depth_q <= '0;
			fresh_q <= CNT_W'(1);
			ov_q    <= 1'b0;
			ob_q    <= '0;
			it_q    <= 1'b0;
		end else begin
			if (rf_we) begin
				regs_q[rf_wa] <= rf_wd;
			end
			if (cmd.latch) begin
				ov_q <= 1'b0;
				ob_q <= '0;
				it_q <= 1'b0;
			end
			if (cmd.exec && (op == OP_OUT)) begin
				ov_q <= 1'b1;
				ob_q <= rc_q[7:0];
			end
			if (cmd.exec && (op == OP_IN)) begin
				it_q <= !inend_q;
			end
			if (cmd.fetch) begin
				pc_q <= pc_nx;
			end else if (cmd.lp_fin) begin
				pc_q <= rc_q[PC_W-1:0];
			end
			if (cmd.append) begin
				len0_q <= len0_q + LEN_W'(1);
			end else if (cmd.lp_fin && !sts.lp_zero) begin
				len0_q <= size_q;
			end
			if (cmd.set_fault) begin
				run_q <= ST_FAULT;
			end else if (cmd.set_halt) begin
				run_q <= ST_HALT;
			end
			if (cmd.map_pop) begin
				depth_q <= dm1;
			end else if (cmd.unmap) begin
				depth_q <= depth_q + CNT_W'(1);
			end
			if (cmd.map_fresh) begin
				fresh_q <= fresh_q + CNT_W'(1);
			end
			if (cmd.map_fin) begin
				mapped_q[id_q] <= 1'b1;
			end else if (cmd.unmap) begin
				mapped_q[rc_q[ID_W-1:0]] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q   <= command;
			word_q  <= program_word;
			inb_q   <= input_byte;
			inend_q <= input_end;
		end
		if (cmd.rd_bc) begin
			instr_q <= mem_rd_q;
			rb_q    <= regs_q[mem_rd_q[FB_LSB +: 3]];
			rc_q    <= regs_q[mem_rd_q[2:0]];
		end
		if (cmd.rd_a) begin
			ra_q <= regs_q[fa];
		end
		if (cmd.map_pop || cmd.map_fresh) begin
			size_q <= rc_q[LEN_W-1:0];
			k_q    <= '0;
		end
		if (cmd.map_fresh) begin
			id_q <= fresh_q[ID_W-1:0];
		end
		if (cmd.pop_take) begin
			id_q <= stk_rd_q;
		end
		if (cmd.cp_init) begin
			id_q   <= acc_lo;
			size_q <= len_sel;
			k_q    <= '0;
		end
		if (cmd.zero_wr || cmd.cp_wr) begin
			k_q <= k_q + LEN_W'(1);
		end
	end

	assign pc_ext          = 32'(pc_q);
	assign status          = run_q;
	assign output_valid    = ov_q;
	assign output_byte     = ob_q;
	assign input_taken     = it_q;
	assign program_counter = pc_ext[9:0];

`ifndef SYNTHESIS
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q != ST_RUN) |=> (run_q == $past(run_q)))
		else $error("stopped status changed");
	a_fetch_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |-> (LEN_W'(pc_q) < len0_q))
		else $error("fetch beyond program length");
	a_map_unused: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.map_fin |-> !mapped_q[id_q])
		else $error("map handed out a live id");
	a_push_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.unmap |=> (depth_q == $past(depth_q) + CNT_W'(1)))
		else $error("free stack depth not advanced");
`endif

endmodule

/* design/umx_ctrl.sv */
`timescale 1ns / 1ps

module umx_ctrl import umx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic done
);

	typedef enum logic [16:0] {
		S_IDLE   = 17'h00001,
		S_DISP   = 17'h00002,
		S_APPEND = 17'h00004,
		S_FETCH  = 17'h00008,
		S_READ   = 17'h00010,
		S_READ2  = 17'h00020,
		S_EXEC   = 17'h00040,
		S_DIV    = 17'h00080,
		S_CHK    = 17'h00100,
		S_LDW    = 17'h00200,
		S_POP    = 17'h00400,
		S_ZERO   = 17'h00800,
		S_MAPFIN = 17'h01000,
		S_CPR    = 17'h02000,
		S_CPW    = 17'h04000,
		S_LPFIN  = 17'h08000,
		S_RESP   = 17'h10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.stopped) begin
					state_d = S_RESP;
				end else if (!sts.exec_cmd) begin
					state_d = S_APPEND;
				end else begin
					state_d = S_FETCH;
				end
			end
			S_APPEND: begin
				if (sts.app_full) begin
					cmd.set_fault = 1'b1;
				end else begin
					cmd.append = 1'b1;
				end
				state_d = S_RESP;
			end
			S_FETCH: begin
				if (sts.pc_oob) begin
					cmd.set_fault = 1'b1;
					state_d       = S_RESP;
				end else begin
					cmd.fetch = 1'b1;
					state_d   = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_bc = 1'b1;
				state_d   = S_READ2;
			end
			S_READ2: begin
				cmd.rd_a = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_RESP;
				case (sts.op)
					OP_CMOV, OP_ADD, OP_MUL, OP_NAND, OP_IMM, OP_OUT, OP_IN: begin
						cmd.exec = 1'b1;
					end
					OP_DIV: begin
						if (sts.rc_zero) begin
							cmd.set_fault = 1'b1;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end
					end
					OP_HALT: begin
						cmd.set_halt = 1'b1;
					end
					OP_LOAD, OP_STORE, OP_LOADP: begin
						cmd.len_rd = 1'b1;
						state_d    = S_CHK;
					end
					OP_MAP: begin
						if (sts.map_bad_size) begin
							cmd.set_fault = 1'b1;
						end else if (!sts.stack_empty) begin
							cmd.map_pop = 1'b1;
							state_d     = S_POP;
						end else if (sts.fresh_out) begin
							cmd.set_fault = 1'b1;
						end else begin
							cmd.map_fresh = 1'b1;
							state_d       = S_ZERO;
						end
					end
					OP_UNMAP: begin
						if (sts.unmap_bad) begin
							cmd.set_fault = 1'b1;
						end else begin
							cmd.unmap = 1'b1;
						end
					end
					default: begin
						cmd.set_fault = 1'b1;
					end
				endcase
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.div_write = 1'b1;
					state_d       = S_RESP;
				end
			end
			S_CHK: begin
				state_d = S_RESP;
				if (!sts.acc_ok) begin
					cmd.set_fault = 1'b1;
				end else if (sts.op == OP_LOAD) begin
					cmd.ld_rd = 1'b1;
					state_d   = S_LDW;
				end else if (sts.op == OP_STORE) begin
					cmd.st_wr = 1'b1;
				end else if (sts.lp_zero) begin
					cmd.lp_fin = 1'b1;
				end else begin
					cmd.cp_init = 1'b1;
					state_d     = S_CPR;
				end
			end
			S_LDW: begin
				cmd.ld_wr = 1'b1;
				state_d   = S_RESP;
			end
			S_POP: begin
				cmd.pop_take = 1'b1;
				state_d      = S_ZERO;
			end
			S_ZERO: begin
				if (sts.k_last) begin
					state_d = S_MAPFIN;
				end else begin
					cmd.zero_wr = 1'b1;
				end
			end
			S_MAPFIN: begin
				cmd.map_fin = 1'b1;
				state_d     = S_RESP;
			end
			S_CPR: begin
				if (sts.k_last) begin
					state_d = S_LPFIN;
				end else begin
					cmd.cp_rd = 1'b1;
					state_d   = S_CPW;
				end
			end
			S_CPW: begin
				cmd.cp_wr = 1'b1;
				state_d   = S_CPR;
			end
			S_LPFIN: begin
				cmd.lp_fin = 1'b1;
				state_d    = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top import umx_pkg::*; ();

	localparam int SEG_COUNT = SEGMENT_COUNT_DEF;
	localparam int SEG_WORDS = SEGMENT_WORDS_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic [1:0] status;
		logic       out_valid;
		logic [7:0] out_byte;
		logic       in_taken;
		logic [9:0] pc;
	} um_result_t;

	// Shadow copy of the machine: predicts one result per accepted command.
	class um_shadow;
		bit [31:0] gr [8];
		int        pc;
		bit [31:0] mem [SEG_COUNT*SEG_WORDS];
		int        seg_len [SEG_COUNT];
		bit        mapped [SEG_COUNT];
		int        free_ids [SEG_COUNT];
		int        free_depth;
		int        fresh_id;
		logic [1:0] run;
		um_result_t expected_results [$];
		int        errors;
		int        checked;

		function new();
			pc = 0;
			free_depth = 0;
			fresh_id = 1;
			run = ST_RUN;
			errors = 0;
			checked = 0;
			foreach (gr[i]) gr[i] = '0;
			foreach (seg_len[i]) seg_len[i] = 0;
			foreach (mapped[i]) mapped[i] = 1'b0;
		endfunction

		function bit access_ok(bit [31:0] id, bit [31:0] off);
			if (id != 0 && (id >= SEG_COUNT || !mapped[id]))
				return 1'b0;
			return off < seg_len[id];
		endfunction

		function bit id_ok(bit [31:0] id);
			return id == 0 || (id < SEG_COUNT && mapped[id]);
		endfunction

		// True when executing w in the present state neither faults nor halts.
		function bit will_run(bit [31:0] w);
			bit [31:0] ra, rb, rc;
			ra = gr[w[8:6]];
			rb = gr[w[5:3]];
			rc = gr[w[2:0]];
			case (w[31:28])
				OP_CMOV, OP_ADD, OP_MUL, OP_NAND, OP_OUT, OP_IN, OP_IMM: return 1'b1;
				OP_LOAD:  return access_ok(rb, rc);
				OP_STORE: return access_ok(ra, rb);
				OP_DIV:   return rc != 0;
				OP_MAP:   return rc <= SEG_WORDS && (free_depth > 0 || fresh_id < SEG_COUNT);
				OP_UNMAP: return rc != 0 && rc < SEG_COUNT && mapped[rc];
				OP_LOADP: begin
					if (!id_ok(rb))
						return 1'b0;
					return rc < seg_len[rb];
				end
				default: return 1'b0;
			endcase
		endfunction

		function logic [1:0] execute(bit [31:0] w, bit [7:0] ib, bit ie,
				inout um_result_t r);
			int a, b, c, id, n;
			a = w[8:6];
			b = w[5:3];
			c = w[2:0];
			case (w[31:28])
				OP_IMM: gr[w[27:25]] = {7'd0, w[24:0]};
				OP_CMOV: if (gr[c] != 0) gr[a] = gr[b];
				OP_LOAD: begin
					if (!access_ok(gr[b], gr[c]))
						return ST_FAULT;
					gr[a] = mem[gr[b]*SEG_WORDS + gr[c]];
				end
				OP_STORE: begin
					if (!access_ok(gr[a], gr[b]))
						return ST_FAULT;
					mem[gr[a]*SEG_WORDS + gr[b]] = gr[c];
				end
				OP_ADD: gr[a] = gr[b] + gr[c];
				OP_MUL: gr[a] = gr[b] * gr[c];
				OP_DIV: begin
					if (gr[c] == 0)
						return ST_FAULT;
					gr[a] = gr[b] / gr[c];
				end
				OP_NAND: gr[a] = ~(gr[b] & gr[c]);
				OP_HALT: return ST_HALT;
				OP_MAP: begin
					if (gr[c] > SEG_WORDS)
						return ST_FAULT;
					if (free_depth > 0) begin
						free_depth--;
						id = free_ids[free_depth];
					end else if (fresh_id < SEG_COUNT) begin
						id = fresh_id;
						fresh_id++;
					end else begin
						return ST_FAULT;
					end
					n = gr[c];
					for (int i = 0; i < n; i++)
						mem[id*SEG_WORDS + i] = '0;
					seg_len[id] = n;
					mapped[id] = 1'b1;
					gr[b] = id;
				end
				OP_UNMAP: begin
					if (gr[c] == 0 || gr[c] >= SEG_COUNT || !mapped[gr[c]])
						return ST_FAULT;
					if (free_depth >= SEG_COUNT)
						return ST_FAULT;
					id = gr[c];
					mapped[id] = 1'b0;
					seg_len[id] = 0;
					free_ids[free_depth] = id;
					free_depth++;
				end
				OP_OUT: begin
					r.out_valid = 1'b1;
					r.out_byte = gr[c][7:0];
				end
				OP_IN: begin
					if (ie) begin
						gr[c] = '1;
					end else begin
						gr[c] = {24'd0, ib};
						r.in_taken = 1'b1;
					end
				end
				OP_LOADP: begin
					if (!id_ok(gr[b]))
						return ST_FAULT;
					id = gr[b];
					if (gr[c] >= seg_len[id])
						return ST_FAULT;
					if (id != 0) begin
						n = seg_len[id];
						for (int i = 0; i < n; i++)
							mem[i] = mem[id*SEG_WORDS + i];
						seg_len[0] = n;
					end
					pc = gr[c];
				end
				default: return ST_FAULT;
			endcase
			return ST_RUN;
		endfunction

		function void note_command(bit cmd, bit [31:0] w, bit [7:0] ib, bit ie);
			um_result_t r;
			r.out_valid = 1'b0;
			r.out_byte = '0;
			r.in_taken = 1'b0;
			if (run == ST_RUN) begin
				if (!cmd) begin
					if (seg_len[0] >= SEG_WORDS) begin
						run = ST_FAULT;
					end else begin
						mem[seg_len[0]] = w;
						seg_len[0]++;
					end
				end else if (pc >= seg_len[0]) begin
					run = ST_FAULT;
				end else begin
					bit [31:0] iw;
					iw = mem[pc];
					pc = (pc + 1 >= SEG_WORDS) ? 0 : pc + 1;
					run = execute(iw, ib, ie, r);
				end
			end
			r.status = run;
			r.pc = pc[9:0];
			expected_results.push_back(r);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(um_result_t got);
			um_result_t e;
			if (expected_results.size() == 0) begin
				report("result with nothing outstanding");
				return;
			end
			e = expected_results.pop_front();
			checked++;
			if (got.status !== e.status)
				report($sformatf("status %0d, expected %0d", got.status, e.status));
			if (got.out_valid !== e.out_valid)
				report($sformatf("output_valid %0b, expected %0b", got.out_valid, e.out_valid));
			if (got.out_byte !== e.out_byte)
				report($sformatf("output_byte %0h, expected %0h", got.out_byte, e.out_byte));
			if (got.in_taken !== e.in_taken)
				report($sformatf("input_taken %0b, expected %0b", got.in_taken, e.in_taken));
			if (got.pc !== e.pc)
				report($sformatf("program_counter %0d, expected %0d", got.pc, e.pc));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        command;
	logic [31:0] program_word;
	logic [7:0]  input_byte;
	logic        input_end;
	logic        done;
	logic [1:0]  status;
	logic        output_valid;
	logic [7:0]  output_byte;
	logic        input_taken;
	logic [9:0]  program_counter;

	um_shadow sb;
	int idle_pct;
	int items_sent;
	int maps_done;
	int quiet_cycles;
	string ending;

	segmented_um_instruction_executor dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .program_word(program_word),
		.input_byte(input_byte), .input_end(input_end), .done(done),
		.status(status), .output_valid(output_valid), .output_byte(output_byte),
		.input_taken(input_taken), .program_counter(program_counter)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		um_result_t got;
		if (arst_n && done) begin
			got.status = status;
			got.out_valid = output_valid;
			got.out_byte = output_byte;
			got.in_taken = input_taken;
			got.pc = program_counter;
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic bit [31:0] op3(op_t op, int a, int b, int c);
		return {op, 19'd0, a[2:0], b[2:0], c[2:0]};
	endfunction

	function automatic bit [31:0] imm_word(int r, bit [31:0] v);
		return {OP_IMM, r[2:0], v[24:0]};
	endfunction

	// One command transfer, with random sender gaps in front of it.
	task automatic issue(bit cmd, bit [31:0] w);
		bit [7:0] ib;
		bit ie;
		ib = $urandom_range(255);
		ie = ($urandom_range(3) == 0);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		program_word <= w;
		input_byte <= ib;
		input_end <= ie;
		do @(posedge clk); while (busy);
		sb.note_command(cmd, w, ib, ie);
		items_sent++;
	endtask

	// Append one instruction at the counter and execute it.
	task automatic run_instr(bit [31:0] w);
		issue(1'b0, w);
		issue(1'b1, $urandom);
	endtask

	task automatic set_reg(int r, bit [31:0] v);
		run_instr(imm_word(r, v));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_mapped(bit need_len);
		int s, id;
		s = $urandom_range(SEG_COUNT - 1);
		for (int i = 0; i < SEG_COUNT; i++) begin
			id = (s + i) % SEG_COUNT;
			if (id != 0 && sb.mapped[id] && (!need_len || sb.seg_len[id] > 0))
				return id;
		end
		return need_len ? 0 : -1;
	endfunction

	// A copy source is usable when its last word always runs cleanly.
	function automatic int pick_copy_source();
		int n;
		for (int id = 1; id < SEG_COUNT; id++) begin
			n = sb.seg_len[id];
			if (sb.mapped[id] && n > 0) begin
				case (sb.mem[id*SEG_WORDS + n - 1][31:28])
					OP_CMOV, OP_ADD, OP_MUL, OP_NAND, OP_OUT, OP_IN, OP_IMM: return id;
					default: ;
				endcase
			end
		end
		return -1;
	endfunction

	function automatic bit [31:0] rand_value();
		case ($urandom_range(5))
			0: return 0;
			1: return 32'h1FFFFFF;
			2: return $urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	function automatic int other_reg(int r);
		return (r + 1 + $urandom_range(6)) % 8;
	endfunction

	task automatic do_map(int size);
		int b, c;
		c = $urandom_range(7);
		b = $urandom_range(7);
		set_reg(c, size);
		run_instr(op3(OP_MAP, $urandom_range(7), b, c));
		maps_done++;
	endtask

	task automatic do_unmap(int id);
		int c;
		c = $urandom_range(7);
		set_reg(c, id);
		run_instr(op3(OP_UNMAP, $urandom_range(7), $urandom_range(7), c));
	endtask

	function automatic int map_size();
		int k;
		k = $urandom_range(99);
		if (k < 90)
			return $urandom_range(12);
		if (k < 97)
			return $urandom_range(64, 13);
		return SEG_WORDS;
	endfunction

	task automatic do_access(bit is_store);
		int id, a, b;
		id = pick_mapped(1'b1);
		a = $urandom_range(7);
		b = other_reg(a);
		set_reg(a, id);
		set_reg(b, $urandom_range(sb.seg_len[id] - 1));
		if (is_store)
			run_instr(op3(OP_STORE, a, b, $urandom_range(7)));
		else
			run_instr(op3(OP_LOAD, $urandom_range(7), a, b));
	endtask

	// Jump within segment zero to a freshly appended instruction.
	task automatic jump_in_place();
		int b, c, l;
		b = $urandom_range(7);
		c = other_reg(b);
		set_reg(b, 0);
		l = sb.seg_len[0];
		set_reg(c, l + 2);
		issue(1'b0, op3(OP_LOADP, $urandom_range(7), b, c));
		issue(1'b0, imm_word($urandom_range(7), rand_value()));
		issue(1'b1, $urandom);
		issue(1'b1, $urandom);
	endtask

	// Replace segment zero by a copy and resume at its last word.
	task automatic copy_program();
		int s, b, c;
		s = pick_copy_source();
		if (s < 0) begin
			if (sb.free_depth == 0 && sb.fresh_id >= SEG_COUNT)
				do_unmap(pick_mapped(1'b0));
			do_map($urandom_range(8, 1));
			s = pick_copy_source();
		end
		b = $urandom_range(7);
		c = other_reg(b);
		set_reg(b, s);
		set_reg(c, sb.seg_len[s] - 1);
		run_instr(op3(OP_LOADP, $urandom_range(7), b, c));
		issue(1'b1, $urandom);
	endtask

	task automatic random_unit();
		int k, a, b, c, id;
		bit [31:0] w;
		k = $urandom_range(99);
		a = $urandom_range(7);
		b = $urandom_range(7);
		c = $urandom_range(7);
		if (sb.seg_len[0] > 950) begin
			copy_program();
		end else if (k < 20) begin
			set_reg(a, rand_value());
		end else if (k < 38) begin
			case ($urandom_range(3))
				0: run_instr(op3(OP_CMOV, a, b, c));
				1: run_instr(op3(OP_ADD, a, b, c));
				2: run_instr(op3(OP_MUL, a, b, c));
				default: run_instr(op3(OP_NAND, a, b, c));
			endcase
		end else if (k < 43) begin
			if (sb.gr[c] == 0)
				set_reg(c, $urandom_range(32'h1FFFFFF, 1));
			run_instr(op3(OP_DIV, a, b, c));
		end else if (k < 50) begin
			run_instr(op3(OP_OUT, a, b, c));
		end else if (k < 56) begin
			run_instr(op3(OP_IN, a, b, c));
		end else if (k < 72) begin
			id = pick_mapped(1'b0);
			if ((k < 64 || id < 0) && (sb.free_depth > 0 || sb.fresh_id < SEG_COUNT))
				do_map(map_size());
			else if (id > 0)
				do_unmap(id);
		end else if (k < 83) begin
			do_access(1'b1);
		end else if (k < 92) begin
			do_access(1'b0);
		end else if (k < 95) begin
			copy_program();
		end else if (k < 97) begin
			jump_in_place();
		end else begin
			// Arbitrary words, kept only when they neither stop nor jump.
			do w = $urandom; while (w[31:28] == OP_LOADP || !sb.will_run(w));
			run_instr(w);
		end
	endtask

	task automatic directed_part();
		set_reg(1, 32'h1FFFFFF);
		set_reg(2, 0);
		run_instr(op3(OP_NAND, 3, 2, 2));
		run_instr(op3(OP_MUL, 4, 3, 3));
		run_instr(op3(OP_ADD, 5, 3, 1));
		run_instr(op3(OP_DIV, 6, 3, 1));
		run_instr(op3(OP_CMOV, 7, 3, 2));
		run_instr(op3(OP_CMOV, 7, 3, 1));
		run_instr(op3(OP_OUT, 0, 0, 3));
		run_instr(op3(OP_IN, 0, 0, 6));
		do_map(0);
		do_map(1);
		do_access(1'b1);
		do_access(1'b0);
		do_unmap(pick_mapped(1'b0));
		do_map(2);
		jump_in_place();
		copy_program();
	endtask

	task automatic finish_run();
		int b, c;
		b = $urandom_range(7);
		c = other_reg(b);
		case ($urandom_range(9))
			0: begin
				ending = "halt";
				run_instr(op3(OP_HALT, 0, 0, 0));
			end
			1: begin
				ending = "division by zero";
				set_reg(c, 0);
				run_instr(op3(OP_DIV, 0, b, c));
			end
			2: begin
				ending = "undefined opcode";
				run_instr({4'(14 + $urandom_range(1)), 28'($urandom)});
			end
			3: begin
				ending = "bad segment load";
				set_reg(b, SEG_COUNT + $urandom_range(100));
				run_instr(op3(OP_LOAD, 0, b, c));
			end
			4: begin
				ending = "oversized map";
				set_reg(c, SEG_WORDS + 1 + $urandom_range(1000));
				run_instr(op3(OP_MAP, 0, b, c));
			end
			5: begin
				ending = "unmap of segment zero";
				set_reg(c, 0);
				run_instr(op3(OP_UNMAP, 0, 0, c));
			end
			6: begin
				ending = "jump beyond program";
				set_reg(b, 0);
				set_reg(c, 32'h1FFFFFF);
				run_instr(op3(OP_LOADP, 0, b, c));
			end
			7: begin
				ending = "fetch beyond program";
				issue(1'b1, $urandom);
			end
			8: begin
				ending = "counter wrap then full program segment";
				if (sb.free_depth == 0 && sb.fresh_id >= SEG_COUNT)
					do_unmap(pick_mapped(1'b0));
				set_reg(c, SEG_WORDS);
				run_instr(op3(OP_MAP, 0, b, c));
				set_reg(c, SEG_WORDS - 1);
				run_instr(op3(OP_LOADP, 0, b, c));
				issue(1'b1, $urandom);
				issue(1'b1, $urandom);
				issue(1'b0, $urandom);
			end
			default: begin
				ending = "segment ids exhausted";
				set_reg(c, 0);
				while (sb.will_run(op3(OP_MAP, 0, b, c)))
					run_instr(op3(OP_MAP, 0, b, c));
				run_instr(op3(OP_MAP, 0, b, c));
			end
		endcase
		// The stopped machine must ignore everything after this.
		repeat (12)
			issue($urandom_range(1), $urandom);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		command = 1'b0;
		program_word = '0;
		input_byte = '0;
		input_end = 1'b0;
		quiet_cycles = 0;
		items_sent = 0;
		maps_done = 0;
		idle_pct = 31;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_part();
		while (items_sent < 540)
			random_unit();
		drain();
		idle_pct = 58;
		while (items_sent < 1080)
			random_unit();
		idle_pct = 0;
		while (items_sent < 1580)
			random_unit();
		finish_run();
		drain();
		repeat (60) @(posedge clk);
		$display("Sent %0d commands, checked %0d results, %0d segment maps.",
			items_sent, sb.checked, maps_done);
		$display("Program ended by %s.", ending);
		if (sb.errors == 0 && sb.expected_results.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
